### src/fit_policy_block_allocator_assert.svh
// Assertion macros used by the allocator RTL.
// Each expects signals named clock and reset in the using module.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// Check an invariant at every clock edge outside reset.
`define FPBA_CHECK(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("allocator invariant violated");

// Check a consequence in the same cycle as its trigger.
`define FPBA_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define FPBA_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator next-cycle check failed");

`endif

### src/fpba_pkg.sv
package fpba_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_WIDTH = 16;
   localparam int CELL_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

   localparam int POLICY_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_DATA_W = 5;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   // Best candidate so far, handed from cell to cell during a scan.
   typedef struct packed {
      logic                  found;
      logic [CELL_W-1:0]     pick;
      logic [SIZE_WIDTH-1:0] value;
   } scan_tok_type;

   // Broadcast write into the row of cells.
   typedef struct packed {
      logic                  en;
      logic [CELL_W-1:0]     idx;
      logic [SIZE_WIDTH-1:0] value;
   } cell_wr_type;

endpackage

### src/fpba_cell.sv
module fpba_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fpba_pkg::CELL_W-1:0]        cell_idx,
   input  logic                               part,
   input  logic [fpba_pkg::POLICY_W-1:0]      policy,
   input  logic [fpba_pkg::SIZE_WIDTH-1:0]    req_size,
   input  fpba_pkg::cell_wr_type              wr,
   input  fpba_pkg::scan_tok_type             prev_tok,
   output fpba_pkg::scan_tok_type             next_tok
);
   import fpba_pkg::*;

   logic [SIZE_WIDTH-1:0] value_ff, value_in;
   scan_tok_type          tok_ff, tok_in;
   logic                  fits;
   logic                  take;

   always_comb begin
      fits = part && (value_ff >= req_size);
      // strict compares keep the lower index on a tie
      unique case (policy)
         POLICY_BEST:  take = fits && (!prev_tok.found || (value_ff < prev_tok.value));
         POLICY_WORST: take = fits && (!prev_tok.found || (value_ff > prev_tok.value));
         default:      take = fits && !prev_tok.found;
      endcase

      if (take) begin
         tok_in.found = 1'b1;
         tok_in.pick  = cell_idx;
         tok_in.value = value_ff;
      end else begin
         tok_in = prev_tok;
      end

      value_in = (wr.en && (wr.idx == cell_idx)) ? wr.value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         tok_ff   <= '0;
      end else begin
         value_ff <= value_in;
         tok_ff   <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

### src/fit_policy_block_allocator.sv
// Load: the entry is written and the result registered; no new request until it is emitted.
// Allocate: the candidate token walks the row of NUM_BLOCKS cells, one cell per cycle,
// then the winner is committed to the table and the result registered; the response
// register takes it once the output is free, and no new request is accepted before that.
// Reset (synchronous, active high) zeroes every table entry, fit_policy and block_count.
`include "fit_policy_block_allocator_assert.svh"

module fit_policy_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // block_index[3:0], size_value[19:4]
   input  logic                              req_tuser,   // command[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // chosen_block[3:0], remaining_after[19:4]
   output logic                              rsp_tuser,   // granted[0]
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import fpba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [POLICY_W-1:0]   fit_policy_ff, fit_policy_in;
   logic [COUNT_W-1:0]    block_count_ff, block_count_in;
   logic [SIZE_WIDTH-1:0] req_size_ff, req_size_in;
   logic [CNT_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic                  res_granted_ff, res_granted_in;
   logic [3:0]            res_block_ff, res_block_in;
   logic [15:0]           res_remain_ff, res_remain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff;
   logic [3:0]            rsp_block_ff;
   logic [15:0]           rsp_remain_ff;

   scan_tok_type          tok [NUM_BLOCKS+1];
   logic [NUM_BLOCKS-1:0] part;
   cell_wr_type           wr;
   logic [CNT_W-1:0]      count_sat;

   logic                  req_xfer;
   logic [3:0]            in_idx;
   logic [SIZE_WIDTH-1:0] in_size;
   logic                  load_ok;
   logic                  scan_done;
   logic                  rsp_free;
   logic                  rsp_load;
   logic [SIZE_WIDTH-1:0] grant_value;
   scan_tok_type          tail;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign in_idx     = req_tdata[3:0];
   assign in_size    = SIZE_WIDTH'(req_tdata[19:4]);
   assign load_ok    = (int'(in_idx) < NUM_BLOCKS);

   assign count_sat  = (int'(block_count_ff) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(block_count_ff);

   assign tok[0]      = '0;
   assign tail        = tok[NUM_BLOCKS];
   assign scan_done   = (state_ff == ST_SCAN) && (scan_cnt_ff == CNT_W'(NUM_BLOCKS));
   assign grant_value = tail.value - req_size_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load    = (state_ff == ST_EMIT) && rsp_free;

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      assign part[g] = (CNT_W'(g) < count_sat);

      fpba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (CELL_W'(g)),
         .part     (part[g]),
         .policy   (fit_policy_ff),
         .req_size (req_size_ff),
         .wr       (wr),
         .prev_tok (tok[g]),
         .next_tok (tok[g+1])
      );
   end

   always_comb begin
      state_in       = state_ff;
      req_size_in    = req_size_ff;
      scan_cnt_in    = scan_cnt_ff;
      res_granted_in = res_granted_ff;
      res_block_in   = res_block_ff;
      res_remain_in  = res_remain_ff;
      wr             = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == CMD_LOAD) begin
                  wr.en          = load_ok;
                  wr.idx         = CELL_W'(in_idx);
                  wr.value       = in_size;
                  res_granted_in = 1'b0;
                  res_block_in   = in_idx;
                  res_remain_in  = load_ok ? 16'(in_size) : '0;
                  state_in       = ST_EMIT;
               end else begin
                  req_size_in = in_size;
                  scan_cnt_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               // commit: the token at the tail holds the winner of the walk
               wr.en          = tail.found;
               wr.idx         = tail.pick;
               wr.value       = grant_value;
               res_granted_in = tail.found;
               res_block_in   = tail.found ? 4'(tail.pick) : '0;
               res_remain_in  = tail.found ? 16'(grant_value) : '0;
               state_in       = ST_EMIT;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      fit_policy_in  = fit_policy_ff;
      block_count_in = block_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  fit_policy_in  = csr_wr_data[POLICY_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_wr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_policy_ff  <= '0;
         block_count_ff <= '0;
         scan_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_policy_ff  <= fit_policy_in;
         block_count_ff <= block_count_in;
         scan_cnt_ff    <= scan_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff    <= req_size_in;
      res_granted_ff <= res_granted_in;
      res_block_ff   <= res_block_in;
      res_remain_ff  <= res_remain_in;
      if (rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_block_ff   <= res_block_ff;
         rsp_remain_ff  <= res_remain_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {4'b0000, rsp_remain_ff, rsp_block_ff};

   `FPBA_CHECK(a_scan_cnt_bound, scan_cnt_ff <= CNT_W'(NUM_BLOCKS))
   `FPBA_CHECK_NOW(a_pick_in_range, scan_done && tail.found, CNT_W'(tail.pick) < count_sat)
   `FPBA_CHECK_NOW(a_pick_fits, scan_done && tail.found, tail.value >= req_size_ff)
   `FPBA_CHECK_NEXT(a_alloc_starts_scan, req_xfer && (req_tuser == CMD_ALLOC), (state_ff == ST_SCAN) && (scan_cnt_ff == '0))

endmodule
